[rtl/core/six_axis_servo_slew_ramp_top_defines.svh]
// assertion macros shared by the servo slew ramp checker
// no dependencies; included by files that carry concurrent assertions
`ifndef SIX_AXIS_SERVO_SLEW_RAMP_TOP_DEFINES_SVH
`define SIX_AXIS_SERVO_SLEW_RAMP_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ssr assertion failed");

// next-cycle implication, disabled during reset
`define SSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ssr assertion failed");

`endif

[rtl/core/ssr_pkg.sv]
// types and constants for the servo slew ramp
// no dependencies; imported by the top level, lane and merge modules
`default_nettype none

package ssr_pkg;

    localparam int AXES_MAX = 6;
    localparam int POS_W    = 8;
    localparam int TGT_W    = 9;
    localparam int TICKS_W  = 8;
    localparam int PER_W    = 5;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 56;

    localparam logic [TICKS_W-1:0] PERIOD_MIN = 8'd10;
    localparam logic [TICKS_W-1:0] PERIOD_MAX = 8'd30;

    localparam logic [POS_W-1:0] LO_LIMIT [AXES_MAX] = '{8'd0, 8'd15, 8'd0, 8'd0, 8'd0, 8'd6};
    localparam logic [POS_W-1:0] HI_LIMIT [AXES_MAX] =
        '{8'd180, 8'd165, 8'd180, 8'd180, 8'd180, 8'd73};
    localparam logic [POS_W-1:0] HOME_POS [AXES_MAX] =
        '{8'd0, 8'd45, 8'd180, 8'd180, 8'd90, 8'd10};

    typedef enum logic {
        OP_MOVE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

    typedef struct packed {
        logic             stepped;
        logic             off_after;
        logic [POS_W-1:0] pos;
    } lane_res_t;

    typedef struct packed {
        logic [AXES_MAX*POS_W-1:0] pos;
        logic [AXES_MAX-1:0]       mask;
        logic                      any_off;
    } merge_t;

endpackage

`default_nettype wire

[rtl/core/six_axis_servo_slew_ramp_top.sv]
// servo slew ramp top level: command decode, tick countdown, lanes, output register
// depends on ssr_pkg, ssr_lane and ssr_merge
//
// usage
//   input stream: each beat is a move command (tuser = 0) carrying six joint
//   targets and a step period, or a one-millisecond tick (tuser = 1).
//   a move while idle clamps targets and period and steps every off-target
//   joint by one degree at once; later steps come every period ticks.
//   a move while busy is rejected and changes nothing.
//   output stream: exactly one beat per input beat, carrying the position
//   before the step of every stepped joint, the write mask, busy and rejected.
//   output register: a beat is valid in the cycle after its input is accepted.
//   throughput: one beat per cycle while the output is not stalled; all six lanes
//   compare and step in parallel in the same cycle.
//   reset: joints go to their home positions, not busy, period of ten ticks.
//   stall: the output register holds its beat while m_axis_tready is low;
//   s_axis_tready is high whenever that register is empty or being drained.
`default_nettype none

module six_axis_servo_slew_ramp_top import ssr_pkg::*; #(
    parameter int NUM_JOINTS = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // base_goal, shoulder_goal, elbow_goal, wrist_rot_goal,
    // wrist_ver_goal, grip_goal, step_ticks, zero pad
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    // opcode
    input  wire logic             s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // pos_base, pos_shoulder, pos_elbow, pos_wrist_rot, pos_wrist_ver,
    // pos_grip, write_mask, busy_res, rejected
    output logic [OUT_W-1:0]      m_axis_tdata
);

    localparam int NL = (NUM_JOINTS > AXES_MAX) ? AXES_MAX : NUM_JOINTS;

    logic                 moving_reg, moving_next;
    logic [PER_W-1:0]     countdown_reg, countdown_next;
    logic [PER_W-1:0]     period_reg, period_next;
    logic [PER_W-1:0]     period_in;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     m_data_reg, m_data_next;
    logic                 accept, is_move, rejected;
    logic [TICKS_W-1:0]   ticks_in;
    lane_ctl_t            ctl;
    lane_res_t            res [NL];
    merge_t               mg;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_move       = (op_t'(s_axis_tuser) == OP_MOVE);
    assign ticks_in      = s_axis_tdata[AXES_MAX*TGT_W +: TICKS_W];

    always_comb begin
        if (ticks_in < PERIOD_MIN) begin
            period_in = PER_W'(PERIOD_MIN);
        end else if (ticks_in > PERIOD_MAX) begin
            period_in = PER_W'(PERIOD_MAX);
        end else begin
            period_in = ticks_in[PER_W-1:0];
        end
    end

    assign ctl.load = accept && is_move && !moving_reg;
    assign ctl.step = ctl.load
                   || (accept && !is_move && moving_reg && (countdown_reg <= 5'd1));
    assign rejected = accept && is_move && moving_reg;

    generate
        for (genvar g = 0; g < NL; g++) begin : g_lane
            ssr_lane #(
                .LO   (LO_LIMIT[g]),
                .HI   (HI_LIMIT[g]),
                .HOME (HOME_POS[g])
            ) u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .target_in (s_axis_tdata[g*TGT_W +: TGT_W]),
                .res       (res[g])
            );
        end
    endgenerate

    ssr_merge #(
        .NL (NL)
    ) u_merge (
        .res (res),
        .mg  (mg)
    );

    always_comb begin
        period_next    = ctl.load ? period_in : period_reg;
        moving_next    = ctl.step ? mg.any_off : moving_reg;
        countdown_next = countdown_reg;
        if (ctl.step) begin
            countdown_next = mg.any_off ? period_next : '0;
        end else if (accept && !is_move && moving_reg) begin
            countdown_next = countdown_reg - 5'd1;
        end
        m_valid_next = accept ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
        m_data_next  = accept ? {rejected, moving_next, mg.mask, mg.pos} : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moving_reg    <= 1'b0;
            countdown_reg <= '0;
            period_reg    <= PER_W'(PERIOD_MIN);
            m_valid_reg   <= 1'b0;
        end else begin
            moving_reg    <= moving_next;
            countdown_reg <= countdown_next;
            period_reg    <= period_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

[rtl/core/ssr_lane.sv]
// one joint lane: target clamp, position register and one-degree step
// depends on ssr_pkg
`default_nettype none

module ssr_lane import ssr_pkg::*; #(
    parameter logic [POS_W-1:0] LO   = 8'd0,
    parameter logic [POS_W-1:0] HI   = 8'd180,
    parameter logic [POS_W-1:0] HOME = 8'd0
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire lane_ctl_t               ctl,
    input  wire logic signed [TGT_W-1:0] target_in,
    output lane_res_t                    res
);

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [POS_W-1:0]        tgt_reg, tgt_next;
    logic [POS_W-1:0]        tgt_clamp, tgt_use;
    logic signed [TGT_W:0]   t_ext, lo_s, hi_s;
    logic                    stepped;

    assign t_ext = {target_in[TGT_W-1], target_in};
    assign lo_s  = signed'({2'b00, LO});
    assign hi_s  = signed'({2'b00, HI});

    always_comb begin
        if (t_ext < lo_s) begin
            tgt_clamp = LO;
        end else if (t_ext > hi_s) begin
            tgt_clamp = HI;
        end else begin
            tgt_clamp = t_ext[POS_W-1:0];
        end
    end

    assign tgt_use = ctl.load ? tgt_clamp : tgt_reg;
    assign stepped = ctl.step && (pos_reg != tgt_use);

    always_comb begin
        pos_next = pos_reg;
        if (stepped) begin
            pos_next = (tgt_use > pos_reg) ? pos_reg + 8'd1 : pos_reg - 8'd1;
        end
        tgt_next = tgt_use;
    end

    assign res.stepped   = stepped;
    assign res.off_after = (pos_next != tgt_use);
    assign res.pos       = stepped ? pos_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= HOME;
            tgt_reg <= HOME;
        end else begin
            pos_reg <= pos_next;
            tgt_reg <= tgt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ssr_merge.sv]
// merges lane results into the reported positions, write mask and busy flag
// depends on ssr_pkg
`default_nettype none

module ssr_merge import ssr_pkg::*; #(
    parameter int NL = 6
) (
    input  wire lane_res_t res [NL],
    output merge_t         mg
);

    always_comb begin
        mg = '0;
        for (int j = 0; j < NL; j++) begin
            mg.pos[j*POS_W +: POS_W] = res[j].pos;
            mg.mask[j]               = res[j].stepped;
            mg.any_off               = mg.any_off | res[j].off_after;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ssr_checker.sv]
// port-level checks for the servo slew ramp, bound to the top level
// depends on six_axis_servo_slew_ramp_top_defines.svh
`default_nettype none

`include "six_axis_servo_slew_ramp_top_defines.svh"

module ssr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);

    logic [5:0]  out_mask;
    logic [47:0] out_pos;
    logic        rej_beat, rej_clean, idle_beat, in_beat, out_stall;

    assign out_mask  = m_axis_tdata[53:48];
    assign out_pos   = m_axis_tdata[47:0];
    assign rej_beat  = m_axis_tvalid && m_axis_tdata[55];
    assign rej_clean = (out_mask == 6'd0) && m_axis_tdata[54];
    assign idle_beat = m_axis_tvalid && (out_mask == 6'd0);
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a rejected move steps nothing and reports busy
    `SSR_ASSERT_NOW(a_reject_idle, aclk, aresetn, rej_beat, rej_clean)
    // no stepped joint means no reported position
    `SSR_ASSERT_NOW(a_pos_zero, aclk, aresetn, idle_beat, out_pos == 48'd0)
    // every accepted beat shows up on the output in the next cycle
    `SSR_ASSERT_NEXT(a_one_cycle, aclk, aresetn, in_beat, m_axis_tvalid)
    // input is open whenever the output register is empty
    `SSR_ASSERT_NOW(a_ready_empty, aclk, aresetn, !m_axis_tvalid, s_axis_tready)
    // a stalled output beat holds
    `SSR_ASSERT_NEXT(a_stall_hold, aclk, aresetn, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind six_axis_servo_slew_ramp_top ssr_checker u_ssr_checker (.*);

`default_nettype wire

[sim/ssr_ramp_checker.sv]
// scoreboard for the servo slew ramp: predicts one output beat per accepted input beat
// and compares every accepted output beat field by field with the oldest prediction
// depends on ssr_pkg; instantiated beside the block by tb_six_axis_servo_slew_ramp_top

module ssr_ramp_checker import ssr_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    // base_goal, shoulder_goal, elbow_goal, wrist_rot_goal,
    // wrist_ver_goal, grip_goal, step_ticks, zero pad
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    // opcode
    input  wire logic             s_axis_tuser,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // pos_base, pos_shoulder, pos_elbow, pos_wrist_rot, pos_wrist_ver,
    // pos_grip, write_mask, busy_res, rejected
    input  wire logic [OUT_W-1:0] m_axis_tdata,
    output int                    mismatch_count,
    output int                    pending_beats
);

    localparam int STEP_LSB = AXES_MAX * TGT_W;

    typedef struct packed {
        logic                           rejected;
        logic                           busy;
        logic [AXES_MAX-1:0]            mask;
        logic [AXES_MAX-1:0][POS_W-1:0] pos;
    } ramp_beat_t;

    logic [POS_W-1:0] joint_pos  [AXES_MAX];
    logic [POS_W-1:0] joint_goal [AXES_MAX];
    logic [PER_W-1:0] ticks_left;
    logic [PER_W-1:0] ramp_period;
    logic             in_motion;
    ramp_beat_t       ramp_expected [$];
    int               beat_index;

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_count < 40)
            $display("[%0t] output beat %0d: %s expected %0d, got %0d",
                     $time, beat_index, what, want, got);
        mismatch_count++;
    endtask

    task automatic step_joints(inout ramp_beat_t res);
        in_motion = 1'b0;
        for (int j = 0; j < AXES_MAX; j++) begin
            if (joint_pos[j] != joint_goal[j]) begin
                res.pos[j]   = joint_pos[j];
                res.mask[j]  = 1'b1;
                joint_pos[j] = (joint_goal[j] > joint_pos[j]) ? joint_pos[j] + 8'd1
                                                              : joint_pos[j] - 8'd1;
            end
            if (joint_pos[j] != joint_goal[j])
                in_motion = 1'b1;
        end
        ticks_left = in_motion ? ramp_period : '0;
    endtask

    task automatic predict_servo_beat(input logic op, input logic [IN_W-1:0] d,
                                      output ramp_beat_t res);
        int v;
        res = '0;
        if (op_t'(op) == OP_MOVE) begin
            if (in_motion) begin
                res.rejected = 1'b1;
            end else begin
                v = int'(d[STEP_LSB +: TICKS_W]);
                if (v < int'(PERIOD_MIN)) v = int'(PERIOD_MIN);
                if (v > int'(PERIOD_MAX)) v = int'(PERIOD_MAX);
                ramp_period = v[PER_W-1:0];
                for (int j = 0; j < AXES_MAX; j++) begin
                    v = int'($signed(d[j*TGT_W +: TGT_W]));
                    if (v < int'(LO_LIMIT[j])) v = int'(LO_LIMIT[j]);
                    if (v > int'(HI_LIMIT[j])) v = int'(HI_LIMIT[j]);
                    joint_goal[j] = v[POS_W-1:0];
                end
                step_joints(res);
            end
        end else if (in_motion) begin
            if (ticks_left <= 5'd1)
                step_joints(res);
            else
                ticks_left = ticks_left - 5'd1;
        end
        res.busy = in_motion;
    endtask

    always @(posedge aclk) begin : watch
        ramp_beat_t got;
        ramp_beat_t want;
        if (!aresetn) begin
            joint_pos      = HOME_POS;
            joint_goal     = HOME_POS;
            ticks_left     = '0;
            ramp_period    = PERIOD_MIN[PER_W-1:0];
            in_motion      = 1'b0;
            beat_index     = 0;
            mismatch_count = 0;
            ramp_expected.delete();
            pending_beats <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (ramp_expected.size() == 0) begin
                    report_mismatch("beat with nothing outstanding, write_mask", 0,
                                    int'(got.mask));
                end else begin
                    want = ramp_expected.pop_front();
                    for (int j = 0; j < AXES_MAX; j++)
                        if (got.pos[j] !== want.pos[j])
                            report_mismatch($sformatf("position of joint %0d", j),
                                            int'(want.pos[j]), int'(got.pos[j]));
                    if (got.mask !== want.mask)
                        report_mismatch("write_mask", int'(want.mask), int'(got.mask));
                    if (got.busy !== want.busy)
                        report_mismatch("busy_res", int'(want.busy), int'(got.busy));
                    if (got.rejected !== want.rejected)
                        report_mismatch("rejected", int'(want.rejected), int'(got.rejected));
                end
                beat_index++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_servo_beat(s_axis_tuser, s_axis_tdata, want);
                ramp_expected.push_back(want);
            end
            pending_beats <= ramp_expected.size();
        end
    end

endmodule

[sim/tb_six_axis_servo_slew_ramp_top.sv]
// testbench top for the servo slew ramp: clock, reset, move and tick stimulus, output stalls
// depends on ssr_pkg, six_axis_servo_slew_ramp_top and ssr_ramp_checker

module tb_six_axis_servo_slew_ramp_top;
    import ssr_pkg::*;

    localparam int STEP_LSB    = AXES_MAX * TGT_W;
    localparam int ITEM_GOAL   = 450;
    localparam int HOLD_LEN    = 60;
    localparam int CYCLE_LIMIT = 200000;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    int   mismatch_count;
    int   pending_beats;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_tog    = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   beats_sent  = 0;
    int   cycle_count = 0;
    int   aim [AXES_MAX];

    six_axis_servo_slew_ramp_top dut (.*);

    ssr_ramp_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** six_axis_servo_slew_ramp_top: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_tog) begin
            hold_seen     <= hold_tog;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    task automatic send_beat(input op_t op, input logic [IN_W-1:0] d);
        if (int'($urandom_range(99)) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
        beats_sent++;
    endtask

    function automatic logic [IN_W-1:0] random_fields();
        logic [IN_W-1:0] d;
        d = {$urandom, $urandom};
        d[IN_W-1:STEP_LSB+TICKS_W] = '0;
        return d;
    endfunction

    task automatic send_move(input int b, sh, el, wr, wv, gr, st);
        logic [IN_W-1:0] d;
        int              tv [AXES_MAX];
        d  = '0;
        tv = '{b, sh, el, wr, wv, gr};
        for (int j = 0; j < AXES_MAX; j++)
            d[j*TGT_W +: TGT_W] = tv[j][TGT_W-1:0];
        d[STEP_LSB +: TICKS_W] = st[TICKS_W-1:0];
        send_beat(OP_MOVE, d);
    endtask

    // one move near the last aim, the ticks that end its ramp, up to two more ticks
    task automatic run_ramp_sequence();
        int nxt [AXES_MAX];
        int val [AXES_MAX];
        int lo, hi, delta, span, st, per, n_ticks, bad_at, extra;
        span = 0;
        for (int j = 0; j < AXES_MAX; j++) begin
            lo     = int'(LO_LIMIT[j]);
            hi     = int'(HI_LIMIT[j]);
            nxt[j] = aim[j] + int'($urandom_range(4)) - 2;
            if (nxt[j] < lo) nxt[j] = lo;
            if (nxt[j] > hi) nxt[j] = hi;
            val[j] = nxt[j];
            // at a limit, ask past it now and then
            if (nxt[j] == lo && $urandom_range(1) == 0)
                val[j] = lo - 1 - int'($urandom_range(lo + 255));
            else if (nxt[j] == hi && $urandom_range(1) == 0)
                val[j] = hi + 1 + int'($urandom_range(254 - hi));
            delta = (nxt[j] > aim[j]) ? nxt[j] - aim[j] : aim[j] - nxt[j];
            if (delta > span) span = delta;
        end
        st  = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : int'($urandom_range(14));
        per = (st < 10) ? 10 : (st > 30) ? 30 : st;
        send_move(val[0], val[1], val[2], val[3], val[4], val[5], st);
        aim     = nxt;
        n_ticks = (span > 0) ? (span - 1) * per : 0;
        bad_at  = (n_ticks > 1 && $urandom_range(3) == 0) ?
                  int'($urandom_range(n_ticks - 1, 1)) : -1;
        extra   = int'($urandom_range(2));
        for (int k = 0; k < n_ticks + extra; k++) begin
            if (k == bad_at)
                send_beat(OP_MOVE, random_fields());
            send_beat(OP_TICK, random_fields());
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 7;
        rx_idle_pct <= 87;

        // idle tick, then a move onto the home position
        send_beat(OP_TICK, random_fields());
        send_move(0, 45, 180, 180, 90, 10, 0);
        // two-degree ramp with targets past the limits, a move while busy, ticks to finish
        send_move(-256, 43, 255, 181, 92, 8, 9);
        send_move(-256, -256, -256, -256, -256, -256, 255);
        repeat (10) send_beat(OP_TICK, random_fields());
        send_move(-256, 44, 255, 255, 91, 7, 255);
        send_beat(OP_TICK, random_fields());
        send_move(0, 44, 180, 180, 91, 7, 10);
        send_move(-1, 43, 200, 180, 91, 6, 30);
        aim = '{0, 43, 180, 180, 91, 6};

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                tx_idle_pct = 87;
                rx_idle_pct <= 7;
            end else if (phase == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                hold_tog    <= ~hold_tog;
            end
            while (beats_sent < (phase + 1) * ITEM_GOAL / 3)
                run_ramp_sequence();
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge aclk); while (pending_beats != 0);
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("** six_axis_servo_slew_ramp_top: PASSED **");
        else
            $display("** six_axis_servo_slew_ramp_top: FAILED **");
        $finish;
    end

endmodule
